### sv/shbs_pkg.sv
package shbs_pkg;

    // stream field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned OUT_TD_W = 40;

    typedef logic [WORD_W-1:0] t_word;

    // padding marker byte
    localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;
    // block fill at which the length field starts
    localparam logic [5:0]        LEN_POS  = 6'd56;
    localparam logic [5:0]        FILL_TOP = 6'd63;
    localparam logic [IDX_W-1:0]  IDX_LAST = 3'd7;

    // round constants
    function automatic t_word round_k(input logic [5:0] i);
        t_word k;
        case (i)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    // initial hash values
    function automatic t_word init_h(input logic [IDX_W-1:0] i);
        t_word h;
        case (i)
            3'd0: h = 32'h6a09e667;  3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;  3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;  3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;  3'd7: h = 32'h5be0cd19;
            default: h = '0;
        endcase
        return h;
    endfunction

    function automatic t_word rotr(input t_word v, input int unsigned k);
        return (v >> k) | (v << (WORD_W - k));
    endfunction

    function automatic t_word bsig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word ssig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

### sv/sha256_byte_stream_hasher.sv
// SHA-256 hasher over a byte stream.
// Input channel (s_axis): tdata carries one message byte, tuser[0] says the
// byte is present, tlast ends the message (a byte in the same word belongs to
// the message). tready is high only while the core is idle.
// Output channel (m_axis): eight digest words per message, most significant
// first; tdata[31:0] word, tdata[34:32] word index, tlast on the eighth.
// Throughput: one byte word per cycle while a block fills; each full 64-byte
// block then stalls input for the rounds and hash update on the one round unit.
// Message end: padding goes in one byte per cycle up to the block end (one
// extra block when fewer than 9 bytes remain), then compression, then the
// 8 digest words at one per cycle while the receiver takes them.
// A stalled receiver holds the output register and the core waits in the
// output phase; input is accepted again after the eighth word is loaded.
// Reset (synchronous, i_rst_n low) loads the initial hash, clears the bit
// count and fill, and empties the output register.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] byte_valid
    input  logic        i_s_axis_tlast,   // message_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        o_m_axis_tlast    // digest_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COMP = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_PAD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_cnt;
    logic [5:0]  r_fill;
    logic [63:0] r_bitlen;
    logic [63:0] r_len;
    logic        r_pend;
    logic        r_p80;
    logic        r_in_len;

    shbs_pkg::t_word r_h [8];
    shbs_pkg::t_word r_v [8];
    shbs_pkg::t_word r_w [16];

    logic        r_oval;
    logic [31:0] r_oword;
    logic [2:0]  r_oidx;
    logic        r_olast;

    logic        in_acc;
    logic        push_en;
    logic [7:0]  push_byte;
    logic        blk_full;
    logic        out_free;

    shbs_pkg::t_word w_sched, w_t, t1, t2, ch, maj;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_oval || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    // byte source: input word or padding
    always_comb begin
        push_en   = 1'b0;
        push_byte = i_s_axis_tdata;
        if (r_state == S_IDLE) begin
            push_en = in_acc && i_s_axis_tuser;
        end else if (r_state == S_PAD) begin
            push_en = 1'b1;
            if (!r_p80) begin
                push_byte = shbs_pkg::PAD_MARK;
            end else if (r_in_len || r_fill == shbs_pkg::LEN_POS) begin
                push_byte = r_len[63:56];
            end else begin
                push_byte = '0;
            end
        end
    end

    assign blk_full = push_en && (r_fill == shbs_pkg::FILL_TOP);

    // round unit
    always_comb begin
        w_sched = shbs_pkg::ssig1(r_w[14]) + r_w[9] + shbs_pkg::ssig0(r_w[1]) + r_w[0];
        w_t     = (r_cnt[5:4] == 2'd0) ? r_w[0] : w_sched;
        ch      = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj     = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1      = r_v[7] + shbs_pkg::bsig1(r_v[4]) + ch + shbs_pkg::round_k(r_cnt) + w_t;
        t2      = shbs_pkg::bsig0(r_v[0]) + maj;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (blk_full) begin
                        n_state = S_COMP;
                    end else if (i_s_axis_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_COMP: begin
                if (r_cnt == 6'd63) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_cnt[2:0] == shbs_pkg::IDX_LAST) begin
                    if (r_in_len) begin
                        n_state = S_OUT;
                    end else if (r_pend) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PAD: begin
                if (blk_full) begin
                    n_state = S_COMP;
                end
            end
            S_OUT: begin
                if (out_free && r_cnt[2:0] == shbs_pkg::IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_fill   <= '0;
            r_bitlen <= '0;
            r_pend   <= 1'b0;
            r_p80    <= 1'b0;
            r_in_len <= 1'b0;
            r_oval   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else if (r_state == S_COMP || r_state == S_FIN
                         || (r_state == S_OUT && out_free)) begin
                r_cnt <= r_cnt + 6'd1;
            end
            if (push_en) begin
                r_fill <= r_fill + 6'd1;
            end
            if (r_state == S_IDLE && in_acc) begin
                if (i_s_axis_tlast) begin
                    r_bitlen <= '0;
                end else if (i_s_axis_tuser) begin
                    r_bitlen <= r_bitlen + 64'd8;
                end
            end
            // padding progress: pending end mark, marker byte sent, length phase
            if (r_state == S_IDLE && in_acc) begin
                r_pend   <= i_s_axis_tlast;
                r_p80    <= 1'b0;
                r_in_len <= 1'b0;
            end else if (r_state == S_PAD) begin
                r_p80 <= 1'b1;
                if (r_p80 && r_fill == shbs_pkg::LEN_POS) begin
                    r_in_len <= 1'b1;
                end
            end
            // output register
            if (r_state == S_OUT && out_free) begin
                r_oval <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // message length snapshot, shifted out a byte at a time
        if (r_state == S_IDLE && in_acc && i_s_axis_tlast) begin
            r_len <= i_s_axis_tuser ? (r_bitlen + 64'd8) : r_bitlen;
        end else if (r_state == S_PAD && r_p80 && (r_in_len || r_fill == shbs_pkg::LEN_POS)) begin
            r_len <= {r_len[55:0], 8'h00};
        end

        // block window: bytes shift in, rounds rotate or extend the schedule
        if (push_en) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= {r_w[j][23:0], r_w[j+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], push_byte};
        end else if (r_state == S_COMP) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= w_t;
        end

        // working variables
        if (blk_full) begin
            for (int j = 0; j < 8; j++) begin
                r_v[j] <= r_h[j];
            end
        end else if (r_state == S_COMP) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end else if (r_state == S_FIN) begin
            for (int j = 0; j < 7; j++) begin
                r_v[j] <= r_v[j+1];
            end
            r_v[7] <= r_v[0];
        end

        // hash words: IV load on reset, one add per cycle on update, IV refill on readout
        if (!i_rst_n) begin
            for (int j = 0; j < 8; j++) begin
                r_h[j] <= shbs_pkg::init_h(3'(j));
            end
        end else if (r_state == S_FIN) begin
            for (int j = 0; j < 7; j++) begin
                r_h[j] <= r_h[j+1];
            end
            r_h[7] <= r_h[0] + r_v[0];
        end else if (r_state == S_OUT && out_free) begin
            for (int j = 0; j < 7; j++) begin
                r_h[j] <= r_h[j+1];
            end
            r_h[7] <= shbs_pkg::init_h(r_cnt[2:0]);
        end

        // output payload
        if (r_state == S_OUT && out_free) begin
            r_oword <= r_h[0];
            r_oidx  <= r_cnt[2:0];
            r_olast <= (r_cnt[2:0] == shbs_pkg::IDX_LAST);
        end
    end

    assign o_m_axis_tvalid = r_oval;
    assign o_m_axis_tdata  = {5'b0, r_oidx, r_oword};
    assign o_m_axis_tlast  = r_olast;

endmodule

### sv/shbs_checker.sv
module shbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)
            && $stable(o_m_axis_tlast))
        else $error("output word changed while stalled");

    // last flag marks exactly the final word index
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[34:32] == shbs_pkg::IDX_LAST)))
        else $error("digest last flag and word index disagree");

    // message end starts padding (or compression if it fills the block), so input stalls next cycle
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("input ready right after message end");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind sha256_byte_stream_hasher shbs_checker u_shbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

### tb/sha256_byte_stream_hasher_test.sv
module sha256_byte_stream_hasher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WORD_TARGET = 460;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned DRAIN_CYCLES = 300;

    // FIPS 180-4 round constants and initial hash
    localparam bit [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam bit [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        bit [31:0]                digest_word;
        bit [shbs_pkg::IDX_W-1:0] word_index;
        bit                       digest_last;
    } t_digest_word;

    // Running SHA-256 of the accepted byte words plus the digest words still owed
    class digest_scoreboard;
        bit [31:0]    hash_state [8];
        bit [63:0]    msg_bits;
        bit [7:0]     block_buf [64];
        int unsigned  block_cnt;
        t_digest_word digests_due [$];
        int unsigned  errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int j = 0; j < 8; j++) hash_state[j] = SHA_IV[j];
            msg_bits  = '0;
            block_cnt = 0;
        endfunction

        function bit [31:0] ror32(bit [31:0] v, int unsigned n);
            return (v >> n) | (v << (32 - n));
        endfunction

        function void compress_block();
            bit [31:0] w [64];
            bit [31:0] v [8];
            bit [31:0] t1;
            bit [31:0] t2;
            for (int i = 0; i < 16; i++)
                w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = w[i-16] + w[i-7]
                     + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                     + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
            for (int j = 0; j < 8; j++) v[j] = hash_state[j];
            for (int i = 0; i < 64; i++) begin
                t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
                t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int j = 0; j < 8; j++) hash_state[j] += v[j];
        endfunction

        function void absorb_byte(bit [7:0] b);
            block_buf[block_cnt] = b;
            block_cnt++;
            if (block_cnt == 64) begin
                compress_block();
                block_cnt = 0;
            end
        endfunction

        // accepted input word: byte first, then padding and digest on end mark
        function void take_word(bit [7:0] data, bit has_byte, bit ends);
            bit [63:0]    len;
            t_digest_word dw;
            if (has_byte) begin
                msg_bits += 64'd8;
                absorb_byte(data);
            end
            if (!ends) return;
            len = msg_bits;
            absorb_byte(shbs_pkg::PAD_MARK);
            while (block_cnt != int'(shbs_pkg::LEN_POS)) absorb_byte(8'h00);
            for (int k = 0; k < 8; k++) absorb_byte(len[63-8*k -: 8]);
            for (int k = 0; k < 8; k++) begin
                dw.digest_word = hash_state[k];
                dw.word_index  = k[shbs_pkg::IDX_W-1:0];
                dw.digest_last = (k[shbs_pkg::IDX_W-1:0] == shbs_pkg::IDX_LAST);
                digests_due.push_back(dw);
            end
            restart();
        endfunction

        function void check_digest_word(bit [shbs_pkg::OUT_TD_W-1:0] tdata, bit tlast);
            t_digest_word dw;
            if (digests_due.size() == 0) begin
                $error("unexpected digest word %h (tlast %0d)", tdata, tlast);
                errors++;
                return;
            end
            dw = digests_due.pop_front();
            if (tdata[31:0] != dw.digest_word) begin
                $error("digest_word: expected %h, got %h", dw.digest_word, tdata[31:0]);
                errors++;
            end
            if (tdata[34:32] != dw.word_index) begin
                $error("word_index: expected %0d, got %0d", dw.word_index, tdata[34:32]);
                errors++;
            end
            if (tlast != dw.digest_last) begin
                $error("digest_last: expected %0d, got %0d", dw.digest_last, tlast);
                errors++;
            end
            if (tdata[shbs_pkg::OUT_TD_W-1:35] != '0) begin
                $error("tdata fill: expected 0, got %h", tdata[shbs_pkg::OUT_TD_W-1:35]);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return digests_due.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_axis_tvalid;
    logic                          o_s_axis_tready;
    logic [7:0]                    i_s_axis_tdata;   // [7:0] data_byte
    logic                          i_s_axis_tuser;   // [0] byte_valid
    logic                          i_s_axis_tlast;   // message_end
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready;
    logic [shbs_pkg::OUT_TD_W-1:0] o_m_axis_tdata;   // [31:0] digest_word, [34:32] word_index
    logic                          o_m_axis_tlast;   // digest_last

    digest_scoreboard sb;
    int unsigned      cycles;
    int unsigned      words_sent;
    bit               send_quiet;

    sha256_byte_stream_hasher uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // mostly short idle stretches, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    // one input word, held until the core takes it
    task automatic send_word(input bit [7:0] data, input bit has_byte, input bit ends);
        int unsigned gap;
        gap = (send_quiet || $urandom_range(0, 1)) ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= 8'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= has_byte;
        i_s_axis_tlast  <= ends;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.take_word(data, has_byte, ends);
        if (has_byte || ends) words_sent++;
    endtask

    // message of len bytes; the end mark rides on the last byte or on its own word
    task automatic send_message(input int unsigned len, input bit end_on_byte);
        int unsigned n;
        n = (end_on_byte && len > 0) ? len - 1 : len;
        for (int unsigned i = 0; i < n; i++) begin
            // ignored word: no byte, no end
            if ($urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, 1'b0);
        end
        if (end_on_byte && len > 0) send_word(8'($urandom), 1'b1, 1'b1);
        else send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // receiver: random stalls with quiet stretches
    initial begin
        int unsigned hold;
        bit          recv_quiet;
        hold = 0;
        recv_quiet = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 299) == 0) recv_quiet = ~recv_quiet;
            if (hold > 0) begin
                i_m_axis_tready <= 1'b0;
                hold--;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (!recv_quiet && $urandom_range(0, 3) == 0) hold = idle_len();
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_digest_word(o_m_axis_tdata, o_m_axis_tlast);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int unsigned r;
        int unsigned len;
        bit [7:0]    boundary_len [10];
        boundary_len = '{8'd55, 8'd56, 8'd57, 8'd63, 8'd64, 8'd65,
                         8'd119, 8'd120, 8'd127, 8'd128};
        sb = new();
        cycles = 0;
        words_sent = 0;
        send_quiet = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = 8'h00;
        i_s_axis_tuser = 1'b0;
        i_s_axis_tlast = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, with a stray data value that must be ignored
        send_word(8'ha5, 1'b0, 1'b1);
        // "abc", end mark on the last byte
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        // single zero byte with the end mark
        send_word(8'h00, 1'b1, 1'b1);
        // single 0xff byte, end mark on its own word
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'hff, 1'b0, 1'b1);
        // idle word, then another empty message
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // byte extremes and the pad marker value as data
        send_quiet = 1'b1;
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h7f, 1'b1, 1'b0);
        send_word(8'h5a, 1'b0, 1'b1);

        // random messages, block boundaries favored
        while (words_sent < WORD_TARGET) begin
            send_quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 55) len = $urandom_range(0, 12);
            else if (r < 80) len = 32'(boundary_len[$urandom_range(0, 9)]);
            else len = $urandom_range(13, 100);
            send_message(len, 1'($urandom_range(0, 1)));
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/shbs_pkg.sv
sv/sha256_byte_stream_hasher.sv
sv/shbs_checker.sv
tb/sha256_byte_stream_hasher_test.sv
